FILE: design/mbdd_pkg.sv
// shared constants and types for the multi-bit dwell debouncer
`default_nettype none

package mbdd_pkg;

    localparam int NUM_BITS   = 16;
    localparam int MASK_W     = 16;
    localparam int TIME_W     = 16;
    localparam int LANE_COUNT = (NUM_BITS < MASK_W) ? NUM_BITS : MASK_W;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index taken from the word address bit
    localparam logic REG_HOLD_TIME = 1'b0;

    // per-step control broadcast to every lane
    typedef struct packed {
        logic              step;
        logic              bypass;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] hold_time;
    } lane_ctrl_t;

    typedef logic [MASK_W-1:0] mask_t;

    // bits that have a lane behind them
    localparam mask_t LANE_MASK = mask_t'((64'd1 << LANE_COUNT) - 64'd1);

endpackage

`default_nettype wire

FILE: design/mbdd_lane.sv
// one debounce lane: dwell timer and stable bit for a single signal
`default_nettype none

module mbdd_lane
    import mbdd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lane_ctrl_t ctrl,
    input  wire logic       raw_bit,
    output logic            stable_bit,
    output logic            stable_bit_next
);

    logic              stable_reg;
    logic              stable_next;
    logic [TIME_W-1:0] timer_reg;
    logic [TIME_W-1:0] timer_next;
    logic [TIME_W:0]   timer_sum;

    assign timer_sum = {1'b0, timer_reg} + {1'b0, ctrl.elapsed};

    always_comb
    begin
        stable_next = stable_reg;
        timer_next  = timer_reg;
        if (ctrl.bypass)
        begin
            stable_next = raw_bit;
            timer_next  = '0;
        end
        else if (raw_bit == stable_reg)
        begin
            timer_next = '0;
        end
        else if (timer_sum >= {1'b0, ctrl.hold_time})
        begin
            // dwell reached, take the new level
            stable_next = ~stable_reg;
            timer_next  = '0;
        end
        else
        begin
            // below hold time, so the sum fits the stored width
            timer_next = timer_sum[TIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            timer_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            stable_reg <= stable_next;
            timer_reg  <= timer_next;
        end
    end

    assign stable_bit      = stable_reg;
    assign stable_bit_next = stable_next;

endmodule

`default_nettype wire

FILE: design/mbdd_merge.sv
// merges lane results into the output mask and holds it in a two-beat buffer
`default_nettype none

module mbdd_merge
    import mbdd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire mask_t lane_mask,
    output logic       full,
    output logic       out_valid,
    input  wire logic  out_stall,
    output mask_t      stable_mask
);

    mask_t      head_reg;
    mask_t      head_next;
    mask_t      skid_reg;
    mask_t      skid_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop = (count_reg != 2'd0) && !out_stall;

    always_comb
    begin
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_next = lane_mask;
                end
                else
                begin
                    skid_next = lane_mask;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = skid_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = lane_mask;
                end
                else
                begin
                    head_next = skid_reg;
                    skid_next = lane_mask;
                end
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign full        = (count_reg == 2'd2);
    assign out_valid   = (count_reg != 2'd0);
    assign stable_mask = head_reg;

endmodule

`default_nettype wire

FILE: design/multi_bit_dwell_debouncer.sv
// top level of the multi-bit dwell debouncer: config register, lanes, merge
// latency: a beat into an empty buffer is offered the cycle after it is accepted
// one beat per cycle unless in_stall; lanes update timers in the accept cycle
// a two-beat output buffer lets input beats keep flowing while a result waits
// reset clears hold time (bypass), all stable bits, all timers and the buffer
`default_nettype none

module multi_bit_dwell_debouncer
    import mbdd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // apb-style config port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    // input beats
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [MASK_W-1:0]     sample_bits,
    input  wire logic [TIME_W-1:0]     elapsed,

    // result beats
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [MASK_W-1:0]     stable_mask
);

    logic [TIME_W-1:0] hold_time_reg;
    logic [TIME_W-1:0] hold_time_next;
    logic              cfg_write;
    logic              in_accept;
    logic              buf_full;
    lane_ctrl_t        lane_ctrl;
    mask_t             lane_state;
    mask_t             lane_next;

    // config register, word address bit selects the register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        hold_time_next = hold_time_reg;
        if (cfg_write && (paddr[2] == REG_HOLD_TIME))
        begin
            hold_time_next = pwdata[TIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg <= '0;
        end
        else
        begin
            hold_time_reg <= hold_time_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_HOLD_TIME: prdata = {{(APB_DATA_W-TIME_W){1'b0}}, hold_time_reg};
            default:       prdata = '0;
        endcase
    end

    // input side only waits when both buffer slots hold a result
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !in_stall;

    // control broadcast to all lanes; zero hold time means pass-through
    assign lane_ctrl.step      = in_accept;
    assign lane_ctrl.bypass    = (hold_time_reg == '0);
    assign lane_ctrl.elapsed   = elapsed;
    assign lane_ctrl.hold_time = hold_time_reg;

    // one lane per signal bit; bits past the lane count read as zero
    for (genvar i = 0; i < MASK_W; i++)
    begin : g_lane
        if (i < LANE_COUNT)
        begin : g_active
            mbdd_lane u_lane (
                .clk             (clk),
                .rst_n           (rst_n),
                .ctrl            (lane_ctrl),
                .raw_bit         (sample_bits[i]),
                .stable_bit      (lane_state[i]),
                .stable_bit_next (lane_next[i])
            );
        end
        else
        begin : g_unused
            assign lane_state[i] = 1'b0;
            assign lane_next[i]  = 1'b0;
        end
    end

    // merge lane results into the output buffer
    mbdd_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (in_accept),
        .lane_mask   (lane_next),
        .full        (buf_full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .stable_mask (stable_mask)
    );

`ifndef SYNTHESIS
    // pass-through step copies the in-range raw bits into the stable state
    a_bypass_copy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (hold_time_reg == '0) |=>
        lane_state == ($past(sample_bits) & LANE_MASK))
        else $error("bypass step did not copy raw mask");

    // input only waits while a result is pending
    a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output buffer");

    // a beat into an empty buffer shows the new stable state next cycle
    a_empty_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !out_valid |=> out_valid && (stable_mask == lane_state))
        else $error("result does not match stable state");

    // state only changes on an accepted beat
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(lane_state))
        else $error("stable state changed without a beat");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
// self-checking testbench for the multi-bit dwell debouncer
`timescale 1ns / 100ps

module tb;
    import mbdd_pkg::*;

    // register location on the apb-style port
    localparam logic [APB_ADDR_W-1:0] HOLD_ADDR = APB_ADDR_W'(4 * REG_HOLD_TIME);
    // cycles in which no beat or apb transfer moves before the run is abandoned
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_SAMPLES = 275;

    // idling styles for either side of the block
    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_LIGHT} idle_style_t;

    // one input beat as it sits in the send queue
    typedef struct packed {
        mask_t             raw;
        logic [TIME_W-1:0] dt;
    } sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    mask_t                 sample_bits = '0;
    logic [TIME_W-1:0]     elapsed = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    mask_t                 stable_mask;

    multi_bit_dwell_debouncer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_bits (sample_bits),
        .elapsed     (elapsed),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .stable_mask (stable_mask)
    );

    always #10 clk = ~clk;

    // debouncer state mirrored on the testbench side
    logic [TIME_W-1:0] hold_model = '0;
    mask_t             stable_model = '0;
    logic [TIME_W:0]   dwell_model [LANE_COUNT];

    sample_t     pending_samples [$];
    mask_t       expected_masks [$];
    mask_t       target_mask = '0;
    idle_style_t send_style = IDLE_NONE;
    idle_style_t recv_style = IDLE_NONE;
    int          samples_issued = 0;
    int          results_checked = 0;
    int          fail_count = 0;
    int          send_gap = 0;
    int          recv_hold = 0;
    int          quiet_cycles = 0;
    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;
    sample_t     send_beat;
    mask_t       oldest_mask;

    initial
    begin
        for (int b = 0; b < LANE_COUNT; b++)
        begin
            dwell_model[b] = '0;
        end
    end

    // one debounce step: agreeing lanes clear their timer, disagreeing lanes
    // accumulate elapsed time and flip once the hold time is reached
    function automatic mask_t debounce_step(mask_t raw, logic [TIME_W-1:0] dt);
        logic [TIME_W:0] sum;
        int b;
        for (b = 0; b < LANE_COUNT; b++)
        begin
            if (hold_model == '0)
            begin
                // bypass: raw passes straight through, timers stay clear
                stable_model[b] = raw[b];
                dwell_model[b] = '0;
            end
            else if (raw[b] == stable_model[b])
            begin
                dwell_model[b] = '0;
            end
            else
            begin
                // 17-bit sum, so two full-scale times cannot wrap
                sum = dwell_model[b] + {1'b0, dt};
                if (sum >= {1'b0, hold_model})
                begin
                    stable_model[b] = ~stable_model[b];
                    sum = '0;
                end
                dwell_model[b] = sum;
            end
        end
        return stable_model;
    endfunction

    function automatic int pick_wait(idle_style_t style);
        case (style)
            IDLE_FULL:  return $urandom_range(0, 14);
            IDLE_LIGHT: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 14) : 0;
            default:    return 0;
        endcase
    endfunction

    // elapsed times clustered around the hold time so flips land both early and late
    function automatic logic [TIME_W-1:0] pick_elapsed(int hold);
        int span;
        int v;
        span = (hold == 0) ? 65535 : hold;
        case ($urandom_range(0, 9))
            0:          v = 0;
            1:          v = 65535;
            2, 3, 4, 5: v = $urandom_range(0, span / 3 + 1);
            6, 7:       v = $urandom_range(0, span);
            8:          v = $urandom_range(span / 2, span + span / 2);
            default:    v = $urandom_range(0, 65535);
        endcase
        if (v > 65535)
        begin
            v = 65535;
        end
        return v[TIME_W-1:0];
    endfunction

    // a slowly moving target mask with bounce on a few bits, plus some pure noise
    function automatic mask_t pick_raw();
        if ($urandom_range(0, 19) == 0)
        begin
            target_mask = mask_t'($urandom);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return target_mask;
            5, 6, 7:       return target_mask ^ (mask_t'(1) << $urandom_range(0, MASK_W - 1));
            8:             return target_mask ^ mask_t'($urandom & $urandom);
            default:       return mask_t'($urandom);
        endcase
    endfunction

    task automatic queue_sample(input mask_t raw, input logic [TIME_W-1:0] dt);
        sample_t s;
        s.raw = raw;
        s.dt = dt;
        pending_samples.push_back(s);
        samples_issued++;
    endtask

    // wait until every issued beat has come back checked
    task automatic settle();
        while (results_checked != samples_issued)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // apb transfer: setup phase, then access phase until pready
    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] word,
                              output logic [APB_DATA_W-1:0] rd);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= HOLD_ADDR;
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // write hold time, mirror it, and read it back; upper word bits are don't-care
    task automatic set_hold(input logic [APB_DATA_W-1:0] word);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, word, rd);
        hold_model = word[TIME_W-1:0];
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(hold_model))
        begin
            $error("hold_time readback mismatch: expected %h, actual %h",
                   APB_DATA_W'(hold_model), rd);
            fail_count++;
        end
        @(posedge clk);
    endtask

    // input side: present the next beat after its gap, hold it while stalled
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                send_beat = pending_samples.pop_front();
                sample_bits <= send_beat.raw;
                elapsed <= send_beat.dt;
                in_valid <= 1'b1;
                send_gap = pick_wait(send_style);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side: after each taken beat, stall for a drawn number of valid cycles
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                recv_hold = pick_wait(recv_style);
            end
            else if (recv_hold > 0 && out_valid)
            begin
                recv_hold--;
            end
            out_stall <= (recv_hold > 0);
        end
    end

    // monitor: check the result beat first, then predict for the input beat
    // taken at the same edge (the result of a beat is registered, so it never leaves at the edge it enters)
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        out_taken = rst_n && out_valid && !out_stall;
        if (out_taken)
        begin
            if (expected_masks.size() == 0)
            begin
                $error("stable_mask unexpected beat: expected none, actual %h", stable_mask);
                fail_count++;
            end
            else
            begin
                oldest_mask = expected_masks.pop_front();
                if (stable_mask !== oldest_mask)
                begin
                    $error("stable_mask mismatch: expected %h, actual %h",
                           oldest_mask, stable_mask);
                    fail_count++;
                end
                results_checked++;
            end
        end
        if (in_taken)
        begin
            expected_masks.push_back(debounce_step(sample_bits, elapsed));
        end
    end

    // watchdog on cycles where no beat moves on any port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable && pready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [TIME_W-1:0] plan_hold [6];
        int phase;
        int n;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // bypass straight out of reset
        @(posedge clk);
        queue_sample(16'hFFFF, 16'h0000);
        queue_sample(16'h0000, 16'hFFFF);
        queue_sample(16'hA5A5, 16'h1234);
        settle();

        // timer edges around a hold of 1000
        set_hold(32'd1000);
        queue_sample(16'hFFFF, 16'd999);    // one unit short, no flip
        queue_sample(16'hFFFF, 16'd1);      // reaches hold exactly, flips
        queue_sample(16'h0000, 16'd0);      // disagree with zero time, timers stay at zero
        queue_sample(16'h00FF, 16'd500);    // low byte agrees, high byte starts timing
        queue_sample(16'hFFFF, 16'd0);      // everything agrees, timers cleared
        queue_sample(16'h00FF, 16'd999);    // high byte restarts from zero
        queue_sample(16'h00FF, 16'hFFFF);   // full-scale elapsed, flips
        settle();

        // hold lowered below a running timer: flips on the next zero-time step
        set_hold(32'd65535);
        queue_sample(16'hFF00, 16'd60000);
        settle();
        set_hold(32'd100);
        queue_sample(16'hFF00, 16'd0);
        settle();

        // full-scale hold and the widest timer sum, junk in the upper word
        set_hold(32'hDEAD_FFFF);
        queue_sample(16'h00FF, 16'hFFFE);
        queue_sample(16'h00FF, 16'hFFFF);   // sum beyond 16 bits
        queue_sample(16'h5A5A, 16'hFFFF);   // single step reaches hold
        settle();

        // smallest debounce hold
        set_hold(32'h2152_0001);
        queue_sample(16'h0F0F, 16'd0);
        queue_sample(16'h0F0F, 16'd1);
        settle();

        // random phases over several hold settings, back to bypass in the middle
        plan_hold[0] = 16'd1;
        plan_hold[1] = TIME_W'($urandom_range(2, 40));
        plan_hold[2] = '0;
        plan_hold[3] = TIME_W'($urandom_range(41, 4000));
        plan_hold[4] = 16'hFFFF;
        plan_hold[5] = TIME_W'($urandom_range(4001, 65534));
        for (phase = 0; phase < 6; phase++)
        begin
            set_hold({16'($urandom), plan_hold[phase]});
            send_style = idle_style_t'(phase % 3);
            recv_style = idle_style_t'((phase + 1) % 3);
            for (n = 0; n < PHASE_SAMPLES; n++)
            begin
                queue_sample(pick_raw(), pick_elapsed(plan_hold[phase]));
            end
            settle();
        end

        // let any stray beat show up before judging
        repeat (10) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
